// ===== rtl/silhouette_spline_tessellator_macros.svh =====
// Assertion macros for the silhouette spline tessellator.
// Used by the top level only; no other dependencies.
`ifndef SILHOUETTE_SPLINE_TESSELLATOR_MACROS_SVH
`define SILHOUETTE_SPLINE_TESSELLATOR_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset
`define SST_ASSERT_IMP(lbl, c, r, a, b) \
  lbl: assert property (@(posedge c) disable iff (r) (a) |-> (b)) \
    else $error("sst assertion failed");
// Next-cycle implication, disabled during reset
`define SST_ASSERT_NXT(lbl, c, r, a, b) \
  lbl: assert property (@(posedge c) disable iff (r) (a) |=> (b)) \
    else $error("sst assertion failed");
`else
`define SST_ASSERT_IMP(lbl, c, r, a, b)
`define SST_ASSERT_NXT(lbl, c, r, a, b)
`endif
`endif

// ===== rtl/sst_pkg.sv =====
// Shared constants, types and the spline weight table for the tessellator.
// No dependencies.
`timescale 1ns / 1ps
package sst_pkg;

  localparam int MAX_WIDTH_DEF  = 4096;
  localparam int MAX_HEIGHT_DEF = 4096;
  localparam int CFG_W          = 13;
  localparam int ALPHA_W        = 8;
  localparam int COORD_W        = 22;
  localparam int COORD_MAX      = 2097151;
  localparam int COORD_MIN      = -2097152;
  localparam int QUEUE_DEPTH    = 4;

  // Register indexes
  localparam logic [1:0] REG_THRESHOLD = 2'd0;
  localparam logic [1:0] REG_STEP      = 2'd1;
  localparam logic [1:0] REG_WIDTH     = 2'd2;
  localparam logic [1:0] REG_HEIGHT    = 2'd3;

  // Flags of one finished column
  typedef struct packed {
    logic hit;
    logic is_edge;
  } col_flags_t;

  // Weight of control point i at t = s/5, scaled by 250
  function automatic logic signed [9:0] spline_weight(input logic [2:0] s,
                                                      input logic [1:0] i);
    logic [39:0] row;
    case (s)
      3'd1:    row = {-10'sd16, 10'sd228, 10'sd42,  -10'sd4};
      3'd2:    row = {-10'sd18, 10'sd174, 10'sd106, -10'sd12};
      3'd3:    row = {-10'sd12, 10'sd106, 10'sd174, -10'sd18};
      3'd4:    row = {-10'sd4,  10'sd42,  10'sd228, -10'sd16};
      3'd5:    row = {10'sd0,   10'sd0,   10'sd250, 10'sd0};
      default: row = '0;
    endcase
    return $signed(row[39 - 10 * i -: 10]);
  endfunction

endpackage

// ===== rtl/sst_channels.sv =====
// Handshake channel interfaces: pixel input and segment output.
// Depends on sst_pkg.
`timescale 1ns / 1ps
interface sst_pixel_if;
  logic                              valid;
  logic                              ready;
  logic [sst_pkg::ALPHA_W-1:0]       pixel_alpha;
  modport source (output valid, output pixel_alpha, input ready);
  modport sink   (input valid, input pixel_alpha, output ready);
endinterface

interface sst_segment_if;
  logic                              valid;
  logic                              ready;
  logic signed [sst_pkg::COORD_W-1:0] start_x;
  logic signed [sst_pkg::COORD_W-1:0] start_y;
  logic signed [sst_pkg::COORD_W-1:0] end_x;
  logic signed [sst_pkg::COORD_W-1:0] end_y;
  logic                              rising;
  logic                              group_end;
  logic                              last_of_run;
  modport source (output valid, output start_x, output start_y, output end_x,
                  output end_y, output rising, output group_end,
                  output last_of_run, input ready);
  modport sink   (input valid, input start_x, input start_y, input end_x,
                  input end_y, input rising, input group_end,
                  input last_of_run, output ready);
endinterface

// ===== rtl/sst_queue.sv =====
// Small FIFO of finished columns between the front and back parts.
// Depends on nothing but its parameters.
`timescale 1ns / 1ps
module sst_queue #(
  parameter int DW    = 8,
  parameter int DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  logic [DW-1:0] push_data,
  output logic          full,
  input  logic          pop,
  output logic          not_empty,
  output logic [DW-1:0] pop_data
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [DW-1:0] mem [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [AW:0]   count;
  logic          do_push;
  logic          do_pop;

  assign full      = (count == (AW+1)'(DEPTH));
  assign not_empty = (count != '0);
  assign pop_data  = mem[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  // Store entries
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + (AW+1)'(do_push) - (AW+1)'(do_pop);
    end
  end
endmodule

// ===== rtl/sst_front.sv =====
// Front part: configuration registers, raster tracking and hit detection.
// Depends on sst_pkg and sst_channels.
`timescale 1ns / 1ps
module sst_front #(
  parameter int MAX_WIDTH  = sst_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = sst_pkg::MAX_HEIGHT_DEF,
  parameter int XW = $clog2(MAX_WIDTH + 1),
  parameter int YW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1
) (
  input  logic                      clk,
  input  logic                      rst,
  sst_pixel_if.sink                 pixel,
  input  logic                      cfg_we,
  input  logic [1:0]                cfg_index,
  input  logic [sst_pkg::CFG_W-1:0] cfg_data,
  output logic                      col_push,
  output sst_pkg::col_flags_t       col_flags,
  output logic [XW-1:0]             col_x,
  output logic [YW-1:0]             col_y,
  input  logic                      col_full
);
  localparam int CW = ((XW > sst_pkg::CFG_W) ? XW : sst_pkg::CFG_W) + 1;
  localparam int HB = $clog2(MAX_HEIGHT + 1);
  localparam int HW = ((HB > sst_pkg::CFG_W) ? HB : sst_pkg::CFG_W) + 1;

  logic [sst_pkg::ALPHA_W-1:0] alpha_threshold;
  logic [sst_pkg::CFG_W-1:0]   column_step;
  logic [sst_pkg::CFG_W-1:0]   image_width;
  logic [sst_pkg::CFG_W-1:0]   image_height;

  logic [YW-1:0] row_count;
  logic [XW-1:0] column_pos;
  logic          column_hit;
  logic [YW-1:0] hit_row;

  logic [CW-1:0] width_c;
  logic [CW-1:0] step_c;
  logic [HW-1:0] height_c;
  logic [CW-1:0] x_wide;
  logic [CW-1:0] x_adv;
  logic          col_end;
  logic          is_edge;
  logic          opaque;
  logic          accept;

  // Clamp the live configuration
  always_comb begin
    if (image_width == '0) begin
      width_c = CW'(1);
    end else if (CW'(image_width) > CW'(MAX_WIDTH)) begin
      width_c = CW'(MAX_WIDTH);
    end else begin
      width_c = CW'(image_width);
    end
    if (image_height == '0) begin
      height_c = HW'(1);
    end else if (HW'(image_height) > HW'(MAX_HEIGHT)) begin
      height_c = HW'(MAX_HEIGHT);
    end else begin
      height_c = HW'(image_height);
    end
    step_c = (column_step == '0) ? CW'(1) : CW'(column_step);
  end

  assign col_end = (HW'(row_count) + HW'(1)) >= height_c;
  assign is_edge = CW'(column_pos) >= width_c;
  assign x_wide  = is_edge ? width_c : CW'(column_pos);
  assign x_adv   = x_wide + step_c;
  assign opaque  = pixel.pixel_alpha > alpha_threshold;

  // Stall only a column end that finds the queue full
  assign pixel.ready = !col_end || !col_full;
  assign accept      = pixel.valid && pixel.ready;

  assign col_push          = accept && col_end;
  assign col_flags.hit     = column_hit || opaque;
  assign col_flags.is_edge = is_edge;
  assign col_x             = x_wide[XW-1:0];
  assign col_y             = column_hit ? hit_row : row_count;

  // Hold configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      alpha_threshold <= sst_pkg::ALPHA_W'(128);
      column_step     <= sst_pkg::CFG_W'(1);
      image_width     <= sst_pkg::CFG_W'(4096);
      image_height    <= sst_pkg::CFG_W'(4096);
    end else if (cfg_we) begin
      case (cfg_index)
        sst_pkg::REG_THRESHOLD: alpha_threshold <= cfg_data[sst_pkg::ALPHA_W-1:0];
        sst_pkg::REG_STEP:      column_step     <= cfg_data;
        sst_pkg::REG_WIDTH:     image_width     <= cfg_data;
        sst_pkg::REG_HEIGHT:    image_height    <= cfg_data;
        default:                ;
      endcase
    end
  end

  // Track row, column and first opaque row
  always_ff @(posedge clk) begin
    if (rst) begin
      row_count  <= '0;
      column_pos <= '0;
      column_hit <= 1'b0;
      hit_row    <= '0;
    end else if (accept) begin
      if (col_end) begin
        row_count  <= '0;
        column_hit <= 1'b0;
        hit_row    <= '0;
        if (is_edge) begin
          column_pos <= '0;
        end else if (x_adv >= width_c) begin
          column_pos <= width_c[XW-1:0];
        end else begin
          column_pos <= x_adv[XW-1:0];
        end
      end else begin
        row_count <= row_count + 1'b1;
        if (!column_hit && opaque) begin
          column_hit <= 1'b1;
          hit_row    <= row_count;
        end
      end
    end
  end
endmodule

// ===== rtl/sst_back.sv =====
// Back part: point history, span sequencing and spline segment evaluation.
// Depends on sst_pkg and sst_channels.
`timescale 1ns / 1ps
module sst_back #(
  parameter int XW = 13,
  parameter int YW = 12
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cmd_valid,
  input  sst_pkg::col_flags_t cmd_flags,
  input  logic [XW-1:0]       cmd_x,
  input  logic [YW-1:0]       cmd_y,
  output logic                cmd_pop,
  sst_segment_if.source       seg
);
  localparam int CMW = (XW > YW) ? XW : YW;
  localparam int PW  = CMW + 13;
  localparam int EW  = (PW > 23) ? PW : 23;

  typedef enum logic {IDLE, RUN} state_t;

  state_t               state;
  logic [1:0]           gp;
  logic [XW-1:0]        hx [3];
  logic [YW-1:0]        hy [3];
  logic [XW-1:0]        qx [4];
  logic [YW-1:0]        qy [4];
  logic [2:0]           s;
  logic                 final_span;
  logic                 more;
  logic signed [PW-1:0] prev_x;
  logic signed [PW-1:0] prev_y;

  logic                      out_valid;
  logic [sst_pkg::COORD_W-1:0] out_sx, out_sy, out_ex, out_ey;
  logic                      out_rising, out_gend, out_last;

  logic [1:0]           ngp;
  logic [1:0]           cgp;
  logic                 shift;
  logic                 add_span;
  logic                 close_ok;
  logic                 produce;
  logic                 seg_done;
  logic                 ld;
  logic                 ld_final;
  logic                 ld_more;
  logic [XW-1:0]        ld_qx [4];
  logic [YW-1:0]        ld_qy [4];
  logic [XW-1:0]        cx [3];
  logic [YW-1:0]        cy [3];
  logic signed [PW-1:0] nx;
  logic signed [PW-1:0] ny;

  function automatic logic signed [PW-1:0] wmul(input logic [CMW-1:0] q,
                                                input logic signed [9:0] w);
    return PW'($signed({1'b0, q})) * PW'(w);
  endfunction

  function automatic logic [sst_pkg::COORD_W-1:0] sat(input logic signed [PW-1:0] v);
    logic signed [EW-1:0] e;
    e = EW'(v);
    if (e > EW'(sst_pkg::COORD_MAX)) begin
      e = EW'(sst_pkg::COORD_MAX);
    end else if (e < EW'(sst_pkg::COORD_MIN)) begin
      e = EW'(sst_pkg::COORD_MIN);
    end
    return e[sst_pkg::COORD_W-1:0];
  endfunction

  assign ngp      = (gp == 2'd3) ? 2'd3 : gp + 2'd1;
  assign shift    = (state == IDLE) && cmd_flags.hit;
  assign cgp      = shift ? ngp : gp;
  assign add_span = cmd_flags.hit && (gp >= 2'd2);
  assign close_ok = (!cmd_flags.hit || cmd_flags.is_edge) && (cgp >= 2'd2);
  assign produce  = (state == RUN) && (!out_valid || seg.ready);
  assign seg_done = produce && (s == 3'd5);
  assign cmd_pop  = (state == IDLE);

  // Select history for a closing span, shifted when a point arrives with it
  always_comb begin
    cx[0] = shift ? hx[1] : hx[0];
    cx[1] = shift ? hx[2] : hx[1];
    cx[2] = shift ? cmd_x : hx[2];
    cy[0] = shift ? hy[1] : hy[0];
    cy[1] = shift ? hy[2] : hy[1];
    cy[2] = shift ? cmd_y : hy[2];
  end

  // Decide the next span to load
  always_comb begin
    ld       = 1'b0;
    ld_final = 1'b1;
    ld_more  = 1'b0;
    ld_qx[0] = (cgp == 2'd3) ? cx[0] : cx[1];
    ld_qx[1] = cx[1];
    ld_qx[2] = cx[2];
    ld_qx[3] = cx[2];
    ld_qy[0] = (cgp == 2'd3) ? cy[0] : cy[1];
    ld_qy[1] = cy[1];
    ld_qy[2] = cy[2];
    ld_qy[3] = cy[2];
    if (state == IDLE && cmd_valid) begin
      if (add_span) begin
        ld       = 1'b1;
        ld_final = 1'b0;
        ld_more  = cmd_flags.is_edge;
        ld_qx[0] = (gp == 2'd3) ? hx[0] : hx[1];
        ld_qx[1] = hx[1];
        ld_qx[2] = hx[2];
        ld_qx[3] = cmd_x;
        ld_qy[0] = (gp == 2'd3) ? hy[0] : hy[1];
        ld_qy[1] = hy[1];
        ld_qy[2] = hy[2];
        ld_qy[3] = cmd_y;
      end else if (close_ok) begin
        ld = 1'b1;
      end
    end else if (state == RUN && seg_done && more) begin
      ld = 1'b1;
    end
  end

  // Evaluate the segment end point for the current step
  always_comb begin
    nx = '0;
    ny = '0;
    for (int i = 0; i < 4; i++) begin
      nx = nx + wmul(CMW'(qx[i]), sst_pkg::spline_weight(s, 2'(i)));
      ny = ny + wmul(CMW'(qy[i]), sst_pkg::spline_weight(s, 2'(i)));
    end
  end

  // Sequence spans, update history and register the output item
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      gp        <= '0;
      more      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && seg.ready) begin
        out_valid <= 1'b0;
      end
      if (produce) begin
        out_valid  <= 1'b1;
        out_sx     <= sat(prev_x);
        out_sy     <= sat(prev_y);
        out_ex     <= sat(nx);
        out_ey     <= sat(ny);
        out_rising <= ny < prev_y;
        out_gend   <= final_span && (s == 3'd5);
        out_last   <= (s == 3'd5) && !more;
        prev_x     <= nx;
        prev_y     <= ny;
        s          <= s + 3'd1;
      end
      case (state)
        IDLE: begin
          if (cmd_valid) begin
            if (cmd_flags.hit) begin
              hx[0] <= hx[1];
              hx[1] <= hx[2];
              hx[2] <= cmd_x;
              hy[0] <= hy[1];
              hy[1] <= hy[2];
              hy[2] <= cmd_y;
            end
            gp <= (cmd_flags.hit && (!cmd_flags.is_edge || add_span)) ? ngp : 2'd0;
          end
          if (ld) begin
            state <= RUN;
          end
        end
        RUN: begin
          if (seg_done) begin
            if (more) begin
              gp <= 2'd0;
            end else begin
              state <= IDLE;
            end
          end
        end
        default: state <= IDLE;
      endcase
      if (ld) begin
        qx         <= ld_qx;
        qy         <= ld_qy;
        s          <= 3'd1;
        final_span <= ld_final;
        more       <= ld_more;
        prev_x     <= wmul(CMW'(ld_qx[1]), 10'sd250);
        prev_y     <= wmul(CMW'(ld_qy[1]), 10'sd250);
      end
    end
  end

  assign seg.valid       = out_valid;
  assign seg.start_x     = out_sx;
  assign seg.start_y     = out_sy;
  assign seg.end_x       = out_ex;
  assign seg.end_y       = out_ey;
  assign seg.rising      = out_rising;
  assign seg.group_end   = out_gend;
  assign seg.last_of_run = out_last;
endmodule

// ===== rtl/silhouette_spline_tessellator.sv =====
// Silhouette spline tessellator top level: front, column queue and back.
// Depends on sst_pkg, sst_channels, sst_front, sst_queue, sst_back, macros.
//
// Usage: pixel alphas arrive on the pixel channel column by column, top row
// first, image_height pixels per column. Each column's first opaque row
// becomes a point; runs of hitting columns are tessellated by a Catmull-Rom
// spline, five segments per span, sent on the segment channel.
// Throughput: one pixel per cycle while the column queue has room; pixels
// inside a column are never stalled. A finished column is pushed into a
// four-entry queue; the back part takes a new column from it only while idle,
// not while it produces the segments of a span (at most ten segments per
// column). The first segment of a column passes the queue, the back part's
// span registers and the output register before it appears.
// Reset (rst, synchronous) restores the register defaults, clears the raster
// position and empties the queue; point history needs no clearing.
// When the receiver stalls, the output register holds its segment and the
// back part waits; the queue then absorbs up to four columns before the
// pixel channel stalls at a column end.
// Configuration: write cfg_data to register cfg_index while cfg_we is high.
`timescale 1ns / 1ps
`include "silhouette_spline_tessellator_macros.svh"
module silhouette_spline_tessellator #(
  parameter int MAX_WIDTH  = sst_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = sst_pkg::MAX_HEIGHT_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  sst_pixel_if.sink                 pixel,
  sst_segment_if.source             segment,
  input  logic                      cfg_we,
  input  logic [1:0]                cfg_index,
  input  logic [sst_pkg::CFG_W-1:0] cfg_data
);
  localparam int XW = $clog2(MAX_WIDTH + 1);
  localparam int YW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int DW = XW + YW + 2;

  logic                q_push;
  logic                q_full;
  logic                q_pop;
  logic                q_not_empty;
  sst_pkg::col_flags_t push_flags;
  sst_pkg::col_flags_t pop_flags;
  logic [XW-1:0]       push_x;
  logic [XW-1:0]       pop_x;
  logic [YW-1:0]       push_y;
  logic [YW-1:0]       pop_y;
  logic [DW-1:0]       pop_data;

  sst_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT),
    .XW        (XW),
    .YW        (YW)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .pixel    (pixel),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .col_push (q_push),
    .col_flags(push_flags),
    .col_x    (push_x),
    .col_y    (push_y),
    .col_full (q_full)
  );

  sst_queue #(
    .DW   (DW),
    .DEPTH(sst_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_data({push_flags, push_x, push_y}),
    .full     (q_full),
    .pop      (q_pop),
    .not_empty(q_not_empty),
    .pop_data (pop_data)
  );

  assign pop_flags = pop_data[DW-1 -: 2];
  assign pop_x     = pop_data[YW +: XW];
  assign pop_y     = pop_data[YW-1:0];

  sst_back #(
    .XW(XW),
    .YW(YW)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cmd_valid(q_not_empty),
    .cmd_flags(pop_flags),
    .cmd_x    (pop_x),
    .cmd_y    (pop_y),
    .cmd_pop  (q_pop),
    .seg      (segment)
  );

  // Never push into a full queue
  `SST_ASSERT_IMP(a_no_overflow, clk, rst, q_push, !q_full)
  // The pixel channel stalls only on a full queue
  `SST_ASSERT_IMP(a_stall_cause, clk, rst, !pixel.ready, q_full)
  // A group closes only on the last segment of its column
  `SST_ASSERT_IMP(a_group_end_last, clk, rst,
                  segment.valid && segment.group_end, segment.last_of_run)
endmodule
